// ===== sv/mm3_pkg.sv =====
// mm3_pkg: shared types, constants and mixing functions for the murmur3 x86_32 engine
// no dependencies
`timescale 1ns / 1ps

package mm3_pkg;

    typedef enum logic [1:0] {
        OP_INT  = 2'd0,
        OP_LONG = 2'd1,
        OP_COLL = 2'd2,
        OP_UNIT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_MIX,
        ST_F1,
        ST_F2,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t         op;
        logic        zero;
        logic [63:0] value;
        logic [31:0] count;
        logic        last;
    } item_t;

    localparam int          ADDR_W   = 3;
    localparam logic        REG_SEED = 1'b0;

    localparam logic [31:0] C1       = 32'hcc9e2d51;
    localparam logic [31:0] C2       = 32'h1b873593;
    localparam logic [31:0] MIX_ADD  = 32'he6546b64;
    localparam logic [31:0] F1_MUL   = 32'h85ebca6b;
    localparam logic [31:0] F2_MUL   = 32'hc2b2ae35;
    localparam int          ROT_K    = 15;
    localparam int          ROT_H    = 13;
    localparam logic [31:0] LEN_INT  = 32'd4;
    localparam logic [31:0] LEN_LONG = 32'd8;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // h = rotl(h ^ k, 13) * 5 + const, times five as shift and add
    function automatic logic [31:0] absorb(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rotl(h ^ k, ROT_H);
        return (t << 2) + t + MIX_ADD;
    endfunction

endpackage

// ===== sv/mm3_front.sv =====
// mm3_front: accepts items and classifies them into queue entries
// depends on mm3_pkg
`timescale 1ns / 1ps

module mm3_front
    import mm3_pkg::*;
(
    input  logic        in_valid,
    input  logic [1:0]  mode,
    input  logic [63:0] value,
    input  logic [31:0] count,
    input  logic        last,
    input  logic        q_full,
    output logic        in_stall,
    output logic        q_push,
    output item_t       q_item
);

    op_t op;

    assign op       = op_t'(mode);
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.op    = op;
        q_item.value = value;
        q_item.count = count;
        q_item.last  = last;
        unique case (op)
            OP_INT:  q_item.zero = (value[31:0] == 32'd0);
            OP_LONG: q_item.zero = (value == 64'd0);
            default: q_item.zero = 1'b0;
        endcase
    end

endmodule

// ===== sv/mm3_queue.sv =====
// mm3_queue: short queue of classified items between front and core
// depends on mm3_pkg
`timescale 1ns / 1ps

module mm3_queue
    import mm3_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    input  logic                       pop,
    output item_t                      head,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem [DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    assign head  = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/mm3_core.sv =====
// mm3_core: hash sequencer with one shared 32x32 multiplier, stream state and output register
// depends on mm3_pkg
`timescale 1ns / 1ps

module mm3_core
    import mm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       q_item,
    input  logic        q_empty,
    output logic        q_pop,
    input  logic [31:0] seed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash
);

    state_t      state_reg, state_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] hi_reg, hi_next;
    logic        hi_pend_reg, hi_pend_next;
    logic        absorb_reg, absorb_next;
    logic        emit_reg, emit_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] held_reg, held_next;
    logic        held_v_reg, held_v_next;
    logic [31:0] ucount_reg, ucount_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic        out_free;
    logic        unit_first;
    logic        held_eff;
    logic [31:0] base;
    logic [31:0] n_units;
    logic [15:0] unit;
    logic [31:0] mul_a, mul_b, product;
    logic [31:0] f1_in;
    logic [31:0] h_mix;

    assign out_free   = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign unit_first = (ucount_reg == 32'd0);
    assign held_eff   = held_v_reg && !unit_first;
    assign base       = unit_first ? seed : acc_reg;
    assign n_units    = ucount_reg + 32'd1;
    assign unit       = q_item.value[15:0];
    assign f1_in      = (h_reg ^ len_reg) ^ ((h_reg ^ len_reg) >> 16);
    assign h_mix      = absorb_reg ? absorb(h_reg, x_reg) : (h_reg ^ x_reg);
    assign out_valid  = out_valid_reg;
    assign hash       = out_hash_reg;

    // shared multiplier, low 32 bits of the product
    always_comb
    begin
        unique case (state_reg)
            ST_K1:
            begin
                mul_a = k_reg;
                mul_b = C1;
            end
            ST_K2:
            begin
                mul_a = rotl(x_reg, ROT_K);
                mul_b = C2;
            end
            ST_F1:
            begin
                mul_a = f1_in;
                mul_b = F1_MUL;
            end
            ST_F2:
            begin
                mul_a = x_reg ^ (x_reg >> 13);
                mul_b = F2_MUL;
            end
            default:
            begin
                mul_a = k_reg;
                mul_b = C1;
            end
        endcase
        product = mul_a * mul_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_item.op)
                        OP_INT, OP_LONG: state_next = q_item.zero ? ST_OUT : ST_K1;
                        OP_COLL:         state_next = ST_K1;
                        OP_UNIT:         state_next = (held_eff || q_item.last) ? ST_K1 : ST_IDLE;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_K1:   state_next = ST_K2;
            ST_K2:   state_next = ST_MIX;
            ST_MIX:  state_next = hi_pend_reg ? ST_K1 : (emit_reg ? ST_F1 : ST_IDLE);
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = ST_OUT;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        k_next         = k_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        len_next       = len_reg;
        hi_next        = hi_reg;
        hi_pend_next   = hi_pend_reg;
        absorb_next    = absorb_reg;
        emit_next      = emit_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        held_v_next    = held_v_reg;
        ucount_next    = ucount_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    k_next       = q_item.value[31:0];
                    h_next       = seed;
                    hi_next      = q_item.value[63:32];
                    hi_pend_next = 1'b0;
                    absorb_next  = 1'b1;
                    emit_next    = 1'b1;
                    x_next       = 32'd0;
                    unique case (q_item.op)
                        OP_INT:  len_next = LEN_INT;
                        OP_LONG:
                        begin
                            len_next     = LEN_LONG;
                            hi_pend_next = 1'b1;
                        end
                        OP_COLL: len_next = q_item.count;
                        OP_UNIT:
                        begin
                            h_next      = base;
                            len_next    = {n_units[30:0], 1'b0};
                            ucount_next = q_item.last ? 32'd0 : n_units;
                            if (held_eff)
                            begin
                                k_next      = {unit, held_reg};
                                emit_next   = q_item.last;
                                held_next   = 16'd0;
                                held_v_next = 1'b0;
                            end
                            else if (q_item.last)
                            begin
                                k_next      = {16'd0, unit};
                                absorb_next = 1'b0;
                                held_next   = 16'd0;
                                held_v_next = 1'b0;
                            end
                            else
                            begin
                                held_next   = unit;
                                held_v_next = 1'b1;
                                acc_next    = base;
                            end
                        end
                        default: len_next = LEN_INT;
                    endcase
                end
            end
            ST_K1, ST_K2, ST_F1, ST_F2:
            begin
                x_next = product;
            end
            ST_MIX:
            begin
                h_next = h_mix;
                if (hi_pend_reg)
                begin
                    k_next       = hi_reg;
                    hi_pend_next = 1'b0;
                end
                else if (!emit_reg)
                begin
                    acc_next = h_mix;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = x_reg ^ (x_reg >> 16);
                end
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        h_reg        <= h_next;
        x_reg        <= x_next;
        len_reg      <= len_next;
        hi_reg       <= hi_next;
        hi_pend_reg  <= hi_pend_next;
        absorb_reg   <= absorb_next;
        emit_reg     <= emit_next;
        out_hash_reg <= out_hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= 32'd0;
            held_reg      <= 16'd0;
            held_v_reg    <= 1'b0;
            ucount_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            held_v_reg    <= held_v_next;
            ucount_reg    <= ucount_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/murmur3_x86_32_hash_engine.sv =====
// murmur3_x86_32_hash_engine: top level with seed register, front, queue and core
// int, collection and closing stream items pass K1, K2, MIX, F1, F2 and OUT, long
// items pass K1, K2 and MIX twice first, zero int or long items go straight to OUT
// the core takes a new item only in IDLE, once the previous one is done (a held unit
// item stays in IDLE); the single shared multiplier serves K1, K2, F1, F2; output stalls hold OUT
// reset: rst_n asynchronous active low, clears queue, stream state and seed to zero
`timescale 1ns / 1ps

module murmur3_x86_32_hash_engine
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [63:0]       value,
    input  logic [31:0]       count,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       hash,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0] seed_reg, seed_next;
    logic        q_full, q_empty, q_push, q_pop;
    item_t       q_in, q_head;
    logic [CW-1:0] q_count;

    assign pready = 1'b1;

    always_comb
    begin
        seed_next = seed_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_SEED))
        begin
            seed_next = pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mm3_front u_front (
        .in_valid (in_valid),
        .mode     (mode),
        .value    (value),
        .count    (count),
        .last     (last),
        .q_full   (q_full),
        .in_stall (in_stall),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    mm3_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .seed      (seed_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hash      (hash)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_count != '0))
        else $error("queue popped while empty");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
        else $error("queue count did not follow push");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == CW'(QUEUE_DEPTH)) |-> !q_push)
        else $error("queue pushed while full");

endmodule
